// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the polyline concavity check RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PLCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PLCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/plcc_pkg.sv -----
// Package: constants and types shared by the polyline concavity check.
`timescale 1ns / 1ps
package plcc_pkg;

  // Default coordinate width (signed, 8 fraction bits)
  localparam int COORD_WIDTH_DEF = 24;

  // Close tolerance register
  localparam int TOL_WIDTH = 23;

  // APB port geometry: 32-bit data, one register at byte address 0
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 3;
  localparam int REG_IDX_WIDTH  = APB_ADDR_WIDTH - 2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_CLOSE_TOL = 1'b0;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TOO_FEW = 1'b1;

  // Vertex counter, saturating at three
  typedef logic [1:0] vcount_t;
  localparam vcount_t CNT_ZERO = 2'd0;
  localparam vcount_t CNT_ONE  = 2'd1;
  localparam vcount_t CNT_TWO  = 2'd2;
  localparam vcount_t CNT_SAT  = 2'd3;

  // Control that travels with a vertex through the area stage
  typedef struct packed {
    logic last;     // final vertex of the polyline
    logic too_few;  // fewer than three vertices so far
    logic main_en;  // test the angle ending at this vertex
    logic wrap_en;  // figure closed: also test the wrap angle
  } plcc_ctl_t;

endpackage

// ----- hdl/plcc_window.sv -----
// Vertex window: first/second/older/newer vertices, counter and angle operands.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plcc_window import plcc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic                          last_vertex,
  input  logic        [TOL_WIDTH-1:0]   close_tolerance,
  output plcc_ctl_t                     ctl,
  output logic signed [COORD_WIDTH:0]   m_dx1,
  output logic signed [COORD_WIDTH:0]   m_dy1,
  output logic signed [COORD_WIDTH:0]   m_dx2,
  output logic signed [COORD_WIDTH:0]   m_dy2,
  output logic signed [COORD_WIDTH:0]   w_dx1,
  output logic signed [COORD_WIDTH:0]   w_dy1,
  output logic signed [COORD_WIDTH:0]   w_dx2,
  output logic signed [COORD_WIDTH:0]   w_dy2
);

  localparam int DW     = COORD_WIDTH + 1;
  localparam int CMP_W  = (DW > TOL_WIDTH) ? DW : TOL_WIDTH;

  logic signed [COORD_WIDTH-1:0] first_x, first_y, second_x, second_y;
  logic signed [COORD_WIDTH-1:0] older_x, older_y, newer_x, newer_y;
  vcount_t                       count;
  vcount_t                       count_next;

  logic signed [DW-1:0] cx, cy, fx, fy, sx, sy, ox, oy, nx, ny;
  logic signed [DW-1:0] dfx, dfy;
  logic        [DW-1:0] mag_x, mag_y;
  logic                 within_x, within_y;

  // Sign-extend everything by one bit so differences cannot overflow
  assign cx = {x_coord[COORD_WIDTH-1], x_coord};
  assign cy = {y_coord[COORD_WIDTH-1], y_coord};
  assign fx = {first_x[COORD_WIDTH-1], first_x};
  assign fy = {first_y[COORD_WIDTH-1], first_y};
  assign sx = {second_x[COORD_WIDTH-1], second_x};
  assign sy = {second_y[COORD_WIDTH-1], second_y};
  assign ox = {older_x[COORD_WIDTH-1], older_x};
  assign oy = {older_y[COORD_WIDTH-1], older_y};
  assign nx = {newer_x[COORD_WIDTH-1], newer_x};
  assign ny = {newer_y[COORD_WIDTH-1], newer_y};

  // Angle older -> newer -> incoming
  assign m_dx1 = nx - ox;
  assign m_dy2 = cy - oy;
  assign m_dx2 = cx - ox;
  assign m_dy1 = ny - oy;

  // Wrap angle newer -> incoming -> second
  assign w_dx1 = cx - nx;
  assign w_dy2 = sy - ny;
  assign w_dx2 = sx - nx;
  assign w_dy1 = cy - ny;

  // Closure test: first and incoming vertex within tolerance on both axes
  assign dfx      = fx - cx;
  assign dfy      = fy - cy;
  assign mag_x    = dfx[DW-1] ? DW'(-dfx) : DW'(dfx);
  assign mag_y    = dfy[DW-1] ? DW'(-dfy) : DW'(dfy);
  assign within_x = CMP_W'(mag_x) <= CMP_W'(close_tolerance);
  assign within_y = CMP_W'(mag_y) <= CMP_W'(close_tolerance);

  // Control for this vertex
  always_comb begin
    ctl.last    = last_vertex;
    ctl.main_en = (count >= CNT_TWO);
    ctl.too_few = (count < CNT_TWO);
    ctl.wrap_en = last_vertex && (count >= CNT_TWO) && within_x && within_y;
  end

  // Advance the counter; drop back to zero after the final vertex
  always_comb begin
    if (last_vertex) begin
      count_next = CNT_ZERO;
    end else if (count == CNT_SAT) begin
      count_next = CNT_SAT;
    end else begin
      count_next = count + CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= CNT_ZERO;
      first_x  <= '0;
      first_y  <= '0;
      second_x <= '0;
      second_y <= '0;
      older_x  <= '0;
      older_y  <= '0;
      newer_x  <= '0;
      newer_y  <= '0;
    end else if (accept) begin
      count <= count_next;
      case (count)
        CNT_ZERO: begin
          first_x <= x_coord;
          first_y <= y_coord;
        end
        CNT_ONE: begin
          second_x <= x_coord;
          second_y <= y_coord;
        end
        default: begin
        end
      endcase
      older_x <= newer_x;
      older_y <= newer_y;
      newer_x <= x_coord;
      newer_y <= y_coord;
    end
  end

  `PLCC_ASSERT_NEXT(a_count_restart, accept && last_vertex, count == CNT_ZERO, "count not reset")
  `PLCC_ASSERT_NOW(a_wrap_needs_main, ctl.wrap_en, ctl.last && ctl.main_en, "stray wrap test")

endmodule

// ----- hdl/plcc_area.sv -----
// Area stage: four signed products of the two angle tests, registered.
`timescale 1ns / 1ps
module plcc_area import plcc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            ready,
  input  plcc_ctl_t                       ctl_in,
  input  logic signed [COORD_WIDTH:0]     m_dx1,
  input  logic signed [COORD_WIDTH:0]     m_dy1,
  input  logic signed [COORD_WIDTH:0]     m_dx2,
  input  logic signed [COORD_WIDTH:0]     m_dy2,
  input  logic signed [COORD_WIDTH:0]     w_dx1,
  input  logic signed [COORD_WIDTH:0]     w_dy1,
  input  logic signed [COORD_WIDTH:0]     w_dx2,
  input  logic signed [COORD_WIDTH:0]     w_dy2,
  output logic                            valid,
  input  logic                            down_ready,
  output plcc_ctl_t                       ctl,
  output logic signed [2*COORD_WIDTH+1:0] m_p1,
  output logic signed [2*COORD_WIDTH+1:0] m_p2,
  output logic signed [2*COORD_WIDTH+1:0] w_p1,
  output logic signed [2*COORD_WIDTH+1:0] w_p2
);

  localparam int PW = 2 * COORD_WIDTH + 2;

  logic load;

  // Take a new vertex when empty or when the holder moves on
  assign ready = !valid || down_ready;
  assign load  = in_valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (down_ready) begin
      valid <= 1'b0;
    end
  end

  // Products need no reset
  always_ff @(posedge clk) begin
    if (load) begin
      ctl  <= ctl_in;
      m_p1 <= PW'(m_dx1) * PW'(m_dy2);
      m_p2 <= PW'(m_dx2) * PW'(m_dy1);
      w_p1 <= PW'(w_dx1) * PW'(w_dy2);
      w_p2 <= PW'(w_dx2) * PW'(w_dy1);
    end
  end

endmodule

// ----- hdl/plcc_verdict.sv -----
// Verdict stage: sign tests, sticky concave flag and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plcc_verdict import plcc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid,
  output logic                            ready,
  input  plcc_ctl_t                       ctl,
  input  logic signed [2*COORD_WIDTH+1:0] m_p1,
  input  logic signed [2*COORD_WIDTH+1:0] m_p2,
  input  logic signed [2*COORD_WIDTH+1:0] w_p1,
  input  logic signed [2*COORD_WIDTH+1:0] w_p2,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            is_concave,
  output logic                            status
);

  logic concave_seen;
  logic take;
  logic neg_main, neg_wrap, seen_next;

  // Negative doubled area marks a concave angle
  assign neg_main  = ctl.main_en && (m_p1 < m_p2);
  assign neg_wrap  = ctl.wrap_en && (w_p1 < w_p2);
  assign seen_next = concave_seen || neg_main || neg_wrap;

  // Only a final vertex needs the result register free
  assign ready = !ctl.last || !out_valid || out_ready;
  assign take  = valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      concave_seen <= 1'b0;
      out_valid    <= 1'b0;
      is_concave   <= 1'b0;
      status       <= STATUS_OK;
    end else begin
      if (take && ctl.last) begin
        out_valid    <= 1'b1;
        is_concave   <= ctl.too_few ? 1'b0 : seen_next;
        status       <= ctl.too_few ? STATUS_TOO_FEW : STATUS_OK;
        concave_seen <= 1'b0;
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        if (take) begin
          concave_seen <= seen_next;
        end
      end
    end
  end

  `PLCC_ASSERT_NOW(a_stall_cause, valid && !ready, out_valid && !out_ready, "needless stall")
  `PLCC_ASSERT_NEXT(a_flag_restart, take && ctl.last, !concave_seen, "flag not cleared")
  `PLCC_ASSERT_NOW(a_short_flat, out_valid && (status == STATUS_TOO_FEW), !is_concave, "bad flag")

endmodule

// ----- hdl/polyline_concavity_check_top.sv -----
// Top level of the polyline concavity check: APB register and stage wiring.
`timescale 1ns / 1ps
// Vertices enter one per clock, counter-clockwise, the final one marked by
// last_vertex; each polyline yields one transaction on the result channel
// (is_concave, status), with status 1 when it had fewer than three vertices.
// Throughput is one vertex per cycle: the only stall is a final vertex
// waiting for the result register while an earlier result is still unclaimed.
// An accepted final vertex passes the window subtractors and the four product
// multipliers into the area register, then the area sign compares and the
// sticky flag into the result register. The close tolerance register sits
// at byte address 0 (23 bits, resets to zero); write it only while idle.
module polyline_concavity_check_top import plcc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Vertex channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic                          last_vertex,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_concave,
  output logic                          status,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_WIDTH-1:0]     paddr,
  input  logic [APB_DATA_WIDTH-1:0]     pwdata,
  output logic [APB_DATA_WIDTH-1:0]     prdata,
  output logic                          pready
);

  logic [TOL_WIDTH-1:0]   close_tolerance;
  logic [REG_IDX_WIDTH-1:0] reg_idx;
  logic                   accept;

  plcc_ctl_t                       win_ctl, area_ctl;
  logic signed [COORD_WIDTH:0]     m_dx1, m_dy1, m_dx2, m_dy2;
  logic signed [COORD_WIDTH:0]     w_dx1, w_dy1, w_dx2, w_dy2;
  logic signed [2*COORD_WIDTH+1:0] m_p1, m_p2, w_p1, w_p2;
  logic                            area_valid, verdict_ready;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      close_tolerance <= '0;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_CLOSE_TOL)) begin
      close_tolerance <= pwdata[TOL_WIDTH-1:0];
    end
  end

  always_comb begin
    if (reg_idx == REG_CLOSE_TOL) begin
      prdata = APB_DATA_WIDTH'(close_tolerance);
    end else begin
      prdata = '0;
    end
  end

  assign accept = in_valid && in_ready;

  plcc_window #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .x_coord        (x_coord),
    .y_coord        (y_coord),
    .last_vertex    (last_vertex),
    .close_tolerance(close_tolerance),
    .ctl            (win_ctl),
    .m_dx1          (m_dx1),
    .m_dy1          (m_dy1),
    .m_dx2          (m_dx2),
    .m_dy2          (m_dy2),
    .w_dx1          (w_dx1),
    .w_dy1          (w_dy1),
    .w_dx2          (w_dx2),
    .w_dy2          (w_dy2)
  );

  plcc_area #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_area (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .ready     (in_ready),
    .ctl_in    (win_ctl),
    .m_dx1     (m_dx1),
    .m_dy1     (m_dy1),
    .m_dx2     (m_dx2),
    .m_dy2     (m_dy2),
    .w_dx1     (w_dx1),
    .w_dy1     (w_dy1),
    .w_dx2     (w_dx2),
    .w_dy2     (w_dy2),
    .valid     (area_valid),
    .down_ready(verdict_ready),
    .ctl       (area_ctl),
    .m_p1      (m_p1),
    .m_p2      (m_p2),
    .w_p1      (w_p1),
    .w_p2      (w_p2)
  );

  plcc_verdict #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_verdict (
    .clk       (clk),
    .rst       (rst),
    .valid     (area_valid),
    .ready     (verdict_ready),
    .ctl       (area_ctl),
    .m_p1      (m_p1),
    .m_p2      (m_p2),
    .w_p1      (w_p1),
    .w_p2      (w_p2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_concave(is_concave),
    .status    (status)
  );

endmodule

// ----- tb/sv/polyline_concavity_check_top_tb.sv -----
// Testbench: random and directed polylines checked against a cycle-free predictor.
`timescale 1ns / 1ps
module polyline_concavity_check_top_tb;
  import plcc_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (CW - 1));
  localparam logic [APB_ADDR_WIDTH-1:0] ADDR_CLOSE_TOL = {REG_CLOSE_TOL, 2'b00};
  localparam logic [APB_ADDR_WIDTH-1:0] ADDR_UNUSED = {~REG_CLOSE_TOL, 2'b00};
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam real TWO_PI = 6.283185307179586;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } vertex_t;

  typedef struct packed {
    logic concave;
    logic status;
  } verdict_t;

  // DUT signals; the driven inputs are all known from time zero
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [CW-1:0]          x_coord = '0;
  logic signed [CW-1:0]          y_coord = '0;
  logic                          last_vertex = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          is_concave;
  logic                          status;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0]     paddr = '0;
  logic [APB_DATA_WIDTH-1:0]     pwdata = '0;
  logic [APB_DATA_WIDTH-1:0]     prdata;
  logic                          pready;

  // Stimulus and scoreboard storage
  vertex_t  vertex_q[$];
  verdict_t verdict_q[$];
  int       queued_items = 0;
  int       mismatch_count = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  logic     hold_req = 1'b0;
  logic     hold_ack;
  int       hold_left;

  // Predictor state
  longint   pl_first_x = 0, pl_first_y = 0, pl_second_x = 0, pl_second_y = 0;
  longint   pl_older_x = 0, pl_older_y = 0, pl_newer_x = 0, pl_newer_y = 0;
  vcount_t  pl_count = CNT_ZERO;
  logic     pl_concave = 1'b0;
  logic [TOL_WIDTH-1:0] tol_model = '0;

  polyline_concavity_check_top #(
    .COORD_WIDTH(CW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .last_vertex(last_vertex),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_concave(is_concave),
    .status(status),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Generate the clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Negative doubled area of triangle A, B, C means a clockwise turn
  function automatic logic turns_clockwise(longint ax, longint ay, longint bx, longint by,
                                           longint cx, longint cy);
    return ((bx - ax) * (cy - ay)) < ((cx - ax) * (by - ay));
  endfunction

  function automatic logic near(longint a, longint b, logic [TOL_WIDTH-1:0] tol);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d <= longint'(tol);
  endfunction

  // Advance the polyline state by one accepted vertex, queue its verdict if last
  task automatic track_vertex(input vertex_t v);
    longint   xi, yi;
    verdict_t res;
    xi = longint'($signed(v.x));
    yi = longint'($signed(v.y));
    if (pl_count == CNT_ZERO) begin
      pl_first_x = xi;
      pl_first_y = yi;
    end else if (pl_count == CNT_ONE) begin
      pl_second_x = xi;
      pl_second_y = yi;
    end else if (turns_clockwise(pl_older_x, pl_older_y, pl_newer_x, pl_newer_y, xi, yi)) begin
      pl_concave = 1'b1;
    end
    pl_older_x = pl_newer_x;
    pl_older_y = pl_newer_y;
    pl_newer_x = xi;
    pl_newer_y = yi;
    if (pl_count != CNT_SAT) pl_count = pl_count + 1'b1;
    if (v.last) begin
      if (pl_count == CNT_SAT) begin
        // Closed figure: also test the angle that wraps onto the second vertex
        if (near(pl_first_x, xi, tol_model) && near(pl_first_y, yi, tol_model) &&
            turns_clockwise(pl_older_x, pl_older_y, xi, yi, pl_second_x, pl_second_y))
          pl_concave = 1'b1;
        res.concave = pl_concave;
        res.status  = STATUS_OK;
      end else begin
        res.concave = 1'b0;
        res.status  = STATUS_TOO_FEW;
      end
      verdict_q.push_back(res);
      pl_count   = CNT_ZERO;
      pl_concave = 1'b0;
    end
  endtask

  // Drive vertices from the pending queue; predict on every accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_vertex({x_coord, y_coord, last_vertex});
      if (!in_valid || in_ready) begin
        if (vertex_q.size() != 0 && int'($urandom_range(99, 0)) >= send_idle_pct) begin
          x_coord     <= vertex_q[0].x;
          y_coord     <= vertex_q[0].y;
          last_vertex <= vertex_q[0].last;
          in_valid    <= 1'b1;
          void'(vertex_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Drive out_ready: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_ack  <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (int'($urandom_range(99, 0)) >= stall_pct);
    end
  end

  // Compare each result transaction with the oldest queued verdict
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual is_concave=%0b status=%0b",
                 $time, is_concave, status);
        mismatch_count++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (is_concave !== exp_v.concave) begin
          $display("%0t: is_concave mismatch, expected %0b, actual %0b",
                   $time, exp_v.concave, is_concave);
          mismatch_count++;
        end
        if (status !== exp_v.status) begin
          $display("%0t: status mismatch, expected %0b, actual %0b",
                   $time, exp_v.status, status);
          mismatch_count++;
        end
      end
    end
  end

  // Register write: setup cycle, then access until pready
  task automatic apb_write(input logic [APB_ADDR_WIDTH-1:0] addr,
                           input logic [APB_DATA_WIDTH-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[APB_ADDR_WIDTH-1:2] == REG_CLOSE_TOL) tol_model = data[TOL_WIDTH-1:0];
  endtask

  // Read the tolerance register back and compare with the model copy
  task automatic check_tol_readback();
    logic [APB_DATA_WIDTH-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_CLOSE_TOL;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DATA_WIDTH'(tol_model)) begin
      $display("%0t: close_tolerance readback mismatch, expected %0h, actual %0h",
               $time, APB_DATA_WIDTH'(tol_model), got);
      mismatch_count++;
    end
  endtask

  // Wait until all vertices are in and all verdicts are out, then let the pipe settle
  task automatic wait_idle();
    while (vertex_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_vertex(input longint x, input longint y, input logic last);
    vertex_t v;
    if (x > COORD_MAX) x = COORD_MAX;
    if (x < COORD_MIN) x = COORD_MIN;
    if (y > COORD_MAX) y = COORD_MAX;
    if (y < COORD_MIN) y = COORD_MIN;
    v.x    = x[CW-1:0];
    v.y    = y[CW-1:0];
    v.last = last;
    vertex_q.push_back(v);
    queued_items++;
  endtask

  function automatic longint pick_coord(int kind);
    logic signed [CW-1:0] raw;
    case (kind)
      6, 7: begin
        raw = CW'($urandom);
        return longint'(raw);
      end
      9: begin
        case ($urandom_range(3, 0))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return longint'(int'($urandom_range(128, 0)) - 64);
    endcase
  endfunction

  // Offset inside or just outside the close tolerance; always inside when it is 32 or more
  function automatic longint close_offset();
    int bound;
    bound = (tol_model < 32) ? int'(tol_model) + 1 : 32;
    return longint'(int'($urandom_range(2 * bound, 0)) - bound);
  endfunction

  // Queue one polyline: convex rings, random points, extremes, short and long runs
  task automatic gen_polyline();
    int     kind, n;
    logic   closed;
    longint cx, cy, x0, y0, px, py;
    real    rad, base, stp;
    kind   = $urandom_range(9, 0);
    closed = 1'($urandom_range(1, 0));
    if (kind <= 3) begin
      n    = $urandom_range(10, 3);
      cx   = longint'(int'($urandom_range(1 << 23, 0)) - (1 << 22));
      cy   = longint'(int'($urandom_range(1 << 23, 0)) - (1 << 22));
      rad  = real'((longint'(1) << $urandom_range(20, 4)) + $urandom_range(15, 0));
      base = real'($urandom_range(359, 0)) * TWO_PI / 360.0;
      stp  = TWO_PI / real'(n);
      x0   = 0;
      y0   = 0;
      for (int i = 0; i < n; i++) begin
        px = cx + longint'($rtoi(rad * $cos(base + real'(i) * stp)));
        py = cy + longint'($rtoi(rad * $sin(base + real'(i) * stp)));
        if (i == 0) begin
          x0 = px;
          y0 = py;
        end
        add_vertex(px, py, !closed && i == n - 1);
      end
      if (closed) add_vertex(x0 + close_offset(), y0 + close_offset(), 1'b1);
    end else begin
      case (kind)
        6: n = $urandom_range(6, 1);
        7: n = $urandom_range(2, 1);
        8: n = $urandom_range(30, 10);
        9: n = $urandom_range(6, 3);
        default: n = $urandom_range(8, 1);
      endcase
      if (kind == 7 || n < 3) closed = 1'b0;
      x0 = 0;
      y0 = 0;
      for (int i = 0; i < n; i++) begin
        px = pick_coord(kind);
        py = pick_coord(kind);
        if (i == 0) begin
          x0 = px;
          y0 = py;
        end
        add_vertex(px, py, !closed && i == n - 1);
      end
      if (closed) add_vertex(x0 + close_offset(), y0 + close_offset(), 1'b1);
    end
  endtask

  // Write the tolerance, set the idling mix and run one batch of polylines
  task automatic run_phase(input logic [APB_DATA_WIDTH-1:0] tol, input int idle,
                           input int stall, input int n_items, input logic long_hold);
    int target;
    apb_write(ADDR_CLOSE_TOL, tol);
    check_tol_readback();
    send_idle_pct = idle;
    stall_pct     = stall;
    target = queued_items + n_items;
    while (queued_items < target) gen_polyline();
    if (long_hold) hold_req <= ~hold_req;
    wait_idle();
  endtask

  // Main sequence
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_tol_readback();

    // Directed: too few vertices at the extremes
    add_vertex(COORD_MAX, COORD_MIN, 1'b1);
    add_vertex(COORD_MIN, COORD_MAX, 1'b0);
    add_vertex(COORD_MAX, COORD_MIN, 1'b1);
    // Convex and concave triangles
    add_vertex(0, 0, 1'b0);
    add_vertex(256, 0, 1'b0);
    add_vertex(0, 256, 1'b1);
    add_vertex(0, 0, 1'b0);
    add_vertex(0, 256, 1'b0);
    add_vertex(256, 0, 1'b1);
    // Full-range triangle: widest differences and products
    add_vertex(COORD_MIN, COORD_MIN, 1'b0);
    add_vertex(COORD_MAX, COORD_MIN, 1'b0);
    add_vertex(COORD_MAX, COORD_MAX, 1'b1);
    // Closed figure whose only concave angle is the wrap angle
    add_vertex(0, 0, 1'b0);
    add_vertex(100, -100, 1'b0);
    add_vertex(100, 100, 1'b0);
    add_vertex(-100, 100, 1'b0);
    add_vertex(-100, -100, 1'b0);
    add_vertex(0, 0, 1'b1);
    // Same figure ending one step off the first vertex: open at zero tolerance
    add_vertex(0, 0, 1'b0);
    add_vertex(100, -100, 1'b0);
    add_vertex(100, 100, 1'b0);
    add_vertex(-100, 100, 1'b0);
    add_vertex(-100, -100, 1'b0);
    add_vertex(1, 0, 1'b1);
    wait_idle();

    // Random phases over tolerance settings and idling mixes
    run_phase(32'hFFFF_FFFF, 0, 0, 300, 1'b0);
    apb_write(ADDR_UNUSED, 32'h0000_0005);
    check_tol_readback();
    run_phase(32'd1, 78, 0, 300, 1'b0);
    run_phase(32'd16, 0, 78, 300, 1'b0);
    run_phase(32'd0, 34, 34, 300, 1'b0);
    run_phase(APB_DATA_WIDTH'($urandom_range((1 << TOL_WIDTH) - 1, 0)), 0, 0, 300, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
